[hw/rtl/subtitle_glyph_alpha_blend_macros.svh]
// ---------------------------------------------------------------------------
// subtitle glyph alpha blend assertion macros
// shared property forms for the block checkers
// ---------------------------------------------------------------------------
`ifndef SUBTITLE_GLYPH_ALPHA_BLEND_MACROS_SVH
`define SUBTITLE_GLYPH_ALPHA_BLEND_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGAB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgab assertion failed");

// next-cycle implication, disabled during reset
`define SGAB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgab assertion failed");

`endif

[hw/rtl/sgab_pkg.sv]
// ---------------------------------------------------------------------------
// sgab_pkg
// types, constants and helpers for the subtitle glyph alpha blender
// ---------------------------------------------------------------------------
package sgab_pkg;

    localparam int unsigned NUM_LANES    = 3;
    localparam int unsigned FRONT_STAGES = 7;
    localparam int unsigned DIV_STAGES   = 8;
    localparam int unsigned NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

    // register index, byte address is 4 times this
    typedef enum logic [1:0] {
        REG_RED    = 2'd0,
        REG_GREEN  = 2'd1,
        REG_BLUE   = 2'd2,
        REG_TRANSP = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] transp;
    } cfg_t;

    // per-pixel data that rides alongside the color lanes
    typedef struct packed {
        logic       empty;
        logic [7:0] ga;
        logic [7:0] ra;
    } side_t;

    // stage advance enables from the valid chain
    typedef struct packed {
        logic [FRONT_STAGES-1:0] front;
        logic [DIV_STAGES-1:0]   div;
    } adv_t;

    // exact x / 255 for x <= 255 * 255
    function automatic logic [7:0] div255_16(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

[hw/rtl/sgab_front.sv]
// ---------------------------------------------------------------------------
// sgab_front
// glyph alpha, result alpha and the over-rule numerators, seven stages
// ---------------------------------------------------------------------------
module sgab_front (
    input  logic                                   clk,
    input  sgab_pkg::adv_t                         adv,
    input  sgab_pkg::cfg_t                         cfg,
    input  logic [7:0]                             coverage,
    input  logic [7:0]                             dst_red,
    input  logic [7:0]                             dst_green,
    input  logic [7:0]                             dst_blue,
    input  logic [7:0]                             dst_alpha,
    output logic [sgab_pkg::NUM_LANES-1:0][15:0]   rem,
    output logic [sgab_pkg::NUM_LANES-1:0]         sat,
    output sgab_pkg::side_t                        side
);

    localparam int unsigned NL = sgab_pkg::NUM_LANES;

    logic [7:0]  dst_c   [NL];
    logic [7:0]  glyph_c [NL];

    // stage 0
    logic [15:0] p_ga_reg;
    logic [15:0] dd0_reg [NL];
    logic [7:0]  inv_da0_reg;
    logic        empty0_reg;
    // stage 1
    logic [7:0]  ga1_reg;
    logic [15:0] dd1_reg [NL];
    logic [7:0]  inv_da1_reg;
    logic        empty1_reg;
    // stage 2
    logic [15:0] ra_p_reg;
    logic [23:0] kp2_reg [NL];
    logic [15:0] sp2_reg [NL];
    logic [7:0]  ga2_reg;
    logic        empty2_reg;
    // stage 3
    logic [7:0]  ra3_reg;
    logic [15:0] kq3_reg [NL];
    logic [23:0] kp3_reg [NL];
    logic [15:0] sp3_reg [NL];
    logic [7:0]  ga3_reg;
    logic        empty3_reg;
    // stage 4
    logic [15:0] kept4_reg [NL];
    logic [15:0] sp4_reg   [NL];
    logic [7:0]  ra4_reg;
    logic [7:0]  ga4_reg;
    logic        empty4_reg;
    // stage 5
    logic [16:0] num5_reg [NL];
    logic [7:0]  ra5_reg;
    logic [7:0]  ga5_reg;
    logic        empty5_reg;
    // stage 6
    logic [15:0] rem6_reg [NL];
    logic [NL-1:0] sat6_reg;
    sgab_pkg::side_t side6_reg;

    logic [7:0]  inv_ga2_next;
    logic [23:0] kq3_next [NL];
    logic [23:0] r4_next  [NL];

    assign dst_c[0]   = dst_red;
    assign dst_c[1]   = dst_green;
    assign dst_c[2]   = dst_blue;
    assign glyph_c[0] = cfg.red;
    assign glyph_c[1] = cfg.green;
    assign glyph_c[2] = cfg.blue;

    assign inv_ga2_next = 8'd255 - ga1_reg;

    always_comb
    begin
        for (int c = 0; c < NL; c++)
        begin
            // shift-add estimate of x / 255, low by at most one
            kq3_next[c] = kp2_reg[c] + {8'd0, kp2_reg[c][23:8]} + {16'd0, kp2_reg[c][23:16]};
            r4_next[c]  = kp3_reg[c] - ({kq3_reg[c], 8'h00} - {8'h00, kq3_reg[c]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.front[0])
        begin
            p_ga_reg    <= 16'(coverage) * 16'(8'd255 - cfg.transp);
            inv_da0_reg <= 8'd255 - dst_alpha;
            empty0_reg  <= (dst_alpha == 8'd0);
            for (int c = 0; c < NL; c++)
                dd0_reg[c] <= 16'(dst_c[c]) * 16'(dst_alpha);
        end
        if (adv.front[1])
        begin
            ga1_reg     <= sgab_pkg::div255_16(p_ga_reg);
            inv_da1_reg <= inv_da0_reg;
            empty1_reg  <= empty0_reg;
            for (int c = 0; c < NL; c++)
                dd1_reg[c] <= dd0_reg[c];
        end
        if (adv.front[2])
        begin
            ra_p_reg   <= 16'(inv_da1_reg) * 16'(inv_ga2_next);
            ga2_reg    <= ga1_reg;
            empty2_reg <= empty1_reg;
            for (int c = 0; c < NL; c++)
            begin
                kp2_reg[c] <= 24'(dd1_reg[c]) * 24'(inv_ga2_next);
                sp2_reg[c] <= 16'(glyph_c[c]) * 16'(ga1_reg);
            end
        end
        if (adv.front[3])
        begin
            ra3_reg    <= 8'd255 - sgab_pkg::div255_16(ra_p_reg);
            ga3_reg    <= ga2_reg;
            empty3_reg <= empty2_reg;
            for (int c = 0; c < NL; c++)
            begin
                kq3_reg[c] <= kq3_next[c][23:8];
                kp3_reg[c] <= kp2_reg[c];
                sp3_reg[c] <= sp2_reg[c];
            end
        end
        if (adv.front[4])
        begin
            ra4_reg    <= ra3_reg;
            ga4_reg    <= ga3_reg;
            empty4_reg <= empty3_reg;
            for (int c = 0; c < NL; c++)
            begin
                kept4_reg[c] <= kq3_reg[c] + {15'd0, (r4_next[c] >= 24'd255)};
                sp4_reg[c]   <= sp3_reg[c];
            end
        end
        if (adv.front[5])
        begin
            ra5_reg    <= ra4_reg;
            ga5_reg    <= ga4_reg;
            empty5_reg <= empty4_reg;
            for (int c = 0; c < NL; c++)
                num5_reg[c] <= {1'b0, kept4_reg[c]} + {1'b0, sp4_reg[c]};
        end
        if (adv.front[6])
        begin
            side6_reg.empty <= empty5_reg;
            side6_reg.ga    <= ga5_reg;
            side6_reg.ra    <= ra5_reg;
            for (int c = 0; c < NL; c++)
            begin
                // quotient of 256 or more clips to full scale
                sat6_reg[c] <= (num5_reg[c] >= {1'b0, ra5_reg, 8'h00});
                rem6_reg[c] <= num5_reg[c][15:0];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NL; c++)
            rem[c] = rem6_reg[c];
    end

    assign sat  = sat6_reg;
    assign side = side6_reg;

endmodule

[hw/rtl/sgab_div.sv]
// ---------------------------------------------------------------------------
// sgab_div
// restoring divider by the result alpha, one quotient bit per stage
// ---------------------------------------------------------------------------
module sgab_div (
    input  logic                                   clk,
    input  sgab_pkg::adv_t                         adv,
    input  logic [sgab_pkg::NUM_LANES-1:0][15:0]   rem_in,
    input  logic [sgab_pkg::NUM_LANES-1:0]         sat_in,
    input  sgab_pkg::side_t                        side_in,
    output logic [sgab_pkg::NUM_LANES-1:0][7:0]    quo,
    output sgab_pkg::side_t                        side_out
);

    localparam int unsigned NL = sgab_pkg::NUM_LANES;
    localparam int unsigned NS = sgab_pkg::DIV_STAGES;

    logic [NL-1:0][15:0] rem_reg  [NS];
    logic [NL-1:0][7:0]  quo_reg  [NS];
    logic [NL-1:0]       sat_reg  [NS];
    sgab_pkg::side_t     side_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int unsigned SH = NS - 1 - k;

        logic [NL-1:0][15:0] rem_prev;
        logic [NL-1:0][7:0]  quo_prev;
        logic [NL-1:0]       sat_prev;
        sgab_pkg::side_t     side_prev;
        logic [15:0]         dvs;

        if (k == 0)
        begin : g_first
            assign rem_prev  = rem_in;
            assign quo_prev  = '0;
            assign sat_prev  = sat_in;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign sat_prev  = sat_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign dvs = 16'(side_prev.ra) << SH;

        always_ff @(posedge clk)
        begin
            if (adv.div[k])
            begin
                sat_reg[k]  <= sat_prev;
                side_reg[k] <= side_prev;
                for (int c = 0; c < NL; c++)
                begin
                    if (rem_prev[c] >= dvs)
                    begin
                        rem_reg[k][c] <= rem_prev[c] - dvs;
                        quo_reg[k][c] <= quo_prev[c] | (8'd1 << SH);
                    end
                    else
                    begin
                        rem_reg[k][c] <= rem_prev[c];
                        quo_reg[k][c] <= quo_prev[c];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NL; c++)
            quo[c] = sat_reg[NS-1][c] ? 8'hFF : quo_reg[NS-1][c];
    end

    assign side_out = side_reg[NS-1];

endmodule

[hw/rtl/subtitle_glyph_alpha_blend.sv]
// ---------------------------------------------------------------------------
// subtitle_glyph_alpha_blend
// blends a glyph coverage byte into a straight-alpha rgba pixel
// ---------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled: seven stages
// form the glyph alpha, the result alpha and the over-rule numerators,
// eight stages run a restoring divide by the result alpha one quotient bit
// each, and one output register holds the word. Every stage has its own
// valid bit, so a stall on the output side only stops the input once every
// stage is full; in steady flow the block moves one word per clock in and
// out. Glyph color and transparency must be set over the apb port only
// while no pixel is in flight; the block itself does not enforce this.
module subtitle_glyph_alpha_blend (
    input  logic        clk,
    input  logic        rst_n,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // coverage, dst_red, dst_green, dst_blue, dst_alpha
    // output word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NL = sgab_pkg::NUM_LANES;
    localparam int unsigned NS = sgab_pkg::NUM_STAGES;
    localparam int unsigned NF = sgab_pkg::FRONT_STAGES;
    localparam int unsigned ND = sgab_pkg::DIV_STAGES;

    sgab_pkg::cfg_t      cfg_reg;
    sgab_pkg::reg_idx_t  reg_idx;
    logic                cfg_wr;

    logic [NS-1:0]       vld_reg;
    logic [NS-1:0]       adv_all;
    sgab_pkg::adv_t      adv;

    logic [NL-1:0][15:0] rem;
    logic [NL-1:0]       sat;
    sgab_pkg::side_t     side_front;
    logic [NL-1:0][7:0]  quo;
    sgab_pkg::side_t     side_div;

    logic [7:0]          out_red_reg;
    logic [7:0]          out_green_reg;
    logic [7:0]          out_blue_reg;
    logic [7:0]          out_alpha_reg;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = sgab_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red    <= 8'd255;
            cfg_reg.green  <= 8'd255;
            cfg_reg.blue   <= 8'd255;
            cfg_reg.transp <= 8'd0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                sgab_pkg::REG_RED:    cfg_reg.red    <= pwdata[7:0];
                sgab_pkg::REG_GREEN:  cfg_reg.green  <= pwdata[7:0];
                sgab_pkg::REG_BLUE:   cfg_reg.blue   <= pwdata[7:0];
                sgab_pkg::REG_TRANSP: cfg_reg.transp <= pwdata[7:0];
                default:              cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sgab_pkg::REG_RED:    prdata = {24'd0, cfg_reg.red};
            sgab_pkg::REG_GREEN:  prdata = {24'd0, cfg_reg.green};
            sgab_pkg::REG_BLUE:   prdata = {24'd0, cfg_reg.blue};
            sgab_pkg::REG_TRANSP: prdata = {24'd0, cfg_reg.transp};
            default:              prdata = 32'd0;
        endcase
    end

    // ---------------- valid chain ----------------
    // a stage may load when it is empty or the stage after it moves
    always_comb
    begin
        adv_all[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
            adv_all[i] = !vld_reg[i] || adv_all[i+1];
    end

    assign adv.front = adv_all[NF-1:0];
    assign adv.div   = adv_all[NF+ND-1:NF];
    assign s_tready  = adv_all[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv_all[0])
                vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NS; i++)
                if (adv_all[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- datapath ----------------
    sgab_front u_front (
        .clk       (clk),
        .adv       (adv),
        .cfg       (cfg_reg),
        .coverage  (s_tdata[7:0]),
        .dst_red   (s_tdata[15:8]),
        .dst_green (s_tdata[23:16]),
        .dst_blue  (s_tdata[31:24]),
        .dst_alpha (s_tdata[39:32]),
        .rem       (rem),
        .sat       (sat),
        .side      (side_front)
    );

    sgab_div u_div (
        .clk      (clk),
        .adv      (adv),
        .rem_in   (rem),
        .sat_in   (sat),
        .side_in  (side_front),
        .quo      (quo),
        .side_out (side_div)
    );

    // empty destination takes the glyph color at glyph alpha; the result
    // alpha of a non-empty destination is never below its own alpha, so it never
    // reaches zero there
    always_ff @(posedge clk)
    begin
        if (adv_all[NS-1])
        begin
            if (side_div.empty)
            begin
                out_red_reg   <= cfg_reg.red;
                out_green_reg <= cfg_reg.green;
                out_blue_reg  <= cfg_reg.blue;
                out_alpha_reg <= side_div.ga;
            end
            else
            begin
                out_red_reg   <= quo[0];
                out_green_reg <= quo[1];
                out_blue_reg  <= quo[2];
                out_alpha_reg <= side_div.ra;
            end
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {out_alpha_reg, out_blue_reg, out_green_reg, out_red_reg};

endmodule

[hw/rtl/sgab_checker.sv]
// ---------------------------------------------------------------------------
// sgab_checker
// port-level checks for the glyph alpha blender, bound to the top level
// ---------------------------------------------------------------------------
`include "subtitle_glyph_alpha_blend_macros.svh"

module sgab_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result word holds
    `SGAB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // with no word at the output the pipeline cannot be blocked
    `SGAB_ASSERT_IMP(a_empty_ready, !m_tvalid, s_tready)

    // a ready sink lets every stage move
    `SGAB_ASSERT_IMP(a_sink_ready, m_tready, s_tready)

endmodule

bind subtitle_glyph_alpha_blend sgab_checker u_sgab_checker (.*);

[tb/subtitle_glyph_alpha_blend_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// subtitle_glyph_alpha_blend_tb
// Streams destination pixels with glyph coverage through the blender and
// checks every blended word against a predictor of the straight-alpha over
// rule. Glyph color and transparency are set over apb between phases and
// read back. In some phases the sender idles between bursts and the
// receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
module subtitle_glyph_alpha_blend_tb;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned PHASE_PIXELS = 200;

    // input word, coverage in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] coverage;
    } pixel_t;

    // output word, red in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_BURSTY
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // coverage, dst_red, dst_green, dst_blue, dst_alpha
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // out_red, out_green, out_blue, out_alpha
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sgab_pkg::cfg_t glyph_cfg;
    rgba_t       pending_blends[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    rx_mode_t    rx_mode = RX_ALWAYS;
    bit          tx_idle_en = 1'b0;
    int unsigned burst_left = 0;
    int unsigned rx_hold = 0;

    subtitle_glyph_alpha_blend DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("subtitle_glyph_alpha_blend test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // ---- predictor ----

    function automatic logic [7:0] over_channel(input int unsigned dst, input int unsigned da,
                                                input int unsigned ga, input int unsigned src,
                                                input int unsigned ra);
        int unsigned kept;
        int unsigned v;
        kept = dst * da * (255 - ga) / 255;
        v = (kept + src * ga) / ra;
        // saturate instead of wrapping
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic rgba_t blend_pixel(input pixel_t px, input sgab_pkg::cfg_t cfg);
        int unsigned ga;
        int unsigned ra;
        int unsigned da;
        rgba_t res;
        da = int'(px.alpha);
        ga = int'(px.coverage) * (255 - int'(cfg.transp)) / 255;
        res = '{alpha: px.alpha, blue: px.blue, green: px.green, red: px.red};
        if (da == 0)
        begin
            // empty destination takes the glyph color at glyph alpha
            res = '{alpha: ga[7:0], blue: cfg.blue, green: cfg.green, red: cfg.red};
        end
        else
        begin
            ra = 255 - (255 - da) * (255 - ga) / 255;
            if (ra != 0)
            begin
                res.red   = over_channel(int'(px.red), da, ga, int'(cfg.red), ra);
                res.green = over_channel(int'(px.green), da, ga, int'(cfg.green), ra);
                res.blue  = over_channel(int'(px.blue), da, ga, int'(cfg.blue), ra);
                res.alpha = ra[7:0];
            end
        end
        return res;
    endfunction

    // ---- result checking ----

    always @(negedge clk)
    begin
        case (rx_mode)
            RX_ALWAYS: m_tready = 1'b1;
            RX_RANDOM: m_tready = ($urandom_range(0, 99) < 65);
            default:
            begin
                if (rx_hold == 0)
                begin
                    m_tready = ~m_tready;
                    rx_hold = m_tready ? $urandom_range(0, 10) : $urandom_range(0, 20);
                end
                else
                    rx_hold--;
            end
        endcase
    end

    always @(posedge clk)
    begin
        rgba_t got;
        rgba_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_blends.size() == 0)
                report_mismatch($sformatf("unexpected word %h", m_tdata));
            else
            begin
                want = pending_blends.pop_front();
                if (got.red != want.red)
                    report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                if (got.green != want.green)
                    report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
                if (got.blue != want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
                if (got.alpha != want.alpha)
                    report_mismatch($sformatf("alpha %0d, want %0d", got.alpha, want.alpha));
            end
        end
    end

    // ---- stimulus helpers ----

    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        @(negedge clk);
        s_tdata  = px;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_blends.push_back(blend_pixel(px, glyph_cfg));
        if (tx_idle_en)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    @(negedge clk);
                    s_tvalid = 1'b0;
                    repeat (gap - 1)
                        @(negedge clk);
                end
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_blends.size() != 0)
            @(posedge clk);
        // every sent word has been received, so no word is left in the block
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic apb_check_reg(input sgab_pkg::reg_idx_t idx);
        logic [7:0] want;
        case (idx)
            sgab_pkg::REG_RED:    want = glyph_cfg.red;
            sgab_pkg::REG_GREEN:  want = glyph_cfg.green;
            sgab_pkg::REG_BLUE:   want = glyph_cfg.blue;
            default:              want = glyph_cfg.transp;
        endcase
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] != want)
            report_mismatch($sformatf("reg %s reads %0d, want %0d", idx.name(),
                                      prdata[7:0], want));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apb_write(input sgab_pkg::reg_idx_t idx, input logic [7:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        // upper bits carry noise, only the low byte is kept
        pwdata  = {24'($urandom_range(0, 32'h00FF_FFFF)), val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            sgab_pkg::REG_RED:    glyph_cfg.red = val;
            sgab_pkg::REG_GREEN:  glyph_cfg.green = val;
            sgab_pkg::REG_BLUE:   glyph_cfg.blue = val;
            default:              glyph_cfg.transp = val;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        apb_check_reg(idx);
    endtask

    task automatic set_glyph(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] t);
        wait_idle();
        apb_write(sgab_pkg::REG_RED, r);
        apb_write(sgab_pkg::REG_GREEN, g);
        apb_write(sgab_pkg::REG_BLUE, b);
        apb_write(sgab_pkg::REG_TRANSP, t);
    endtask

    // byte biased toward the extremes
    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'd0;
        if (pick == 1)
            return 8'd255;
        if (pick == 2)
            return 8'($urandom_range(1, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_pixel();
        pixel_t px;
        px.coverage = rand_byte();
        px.red      = rand_byte();
        px.green    = rand_byte();
        px.blue     = rand_byte();
        px.alpha    = rand_byte();
        send_pixel(px);
    endtask

    // ---- tests ----

    task automatic test_reset_values();
        glyph_cfg = '{red: 8'd255, green: 8'd255, blue: 8'd255, transp: 8'd0};
        apb_check_reg(sgab_pkg::REG_RED);
        apb_check_reg(sgab_pkg::REG_GREEN);
        apb_check_reg(sgab_pkg::REG_BLUE);
        apb_check_reg(sgab_pkg::REG_TRANSP);
    endtask

    task automatic test_directed_pixels();
        rx_mode    = RX_ALWAYS;
        tx_idle_en = 1'b0;
        // reset color, opaque glyph; empty destination with and without coverage
        send_pixel('{alpha: 0, blue: 0, green: 0, red: 0, coverage: 0});
        send_pixel('{alpha: 0, blue: 0, green: 0, red: 0, coverage: 255});
        send_pixel('{alpha: 0, blue: 30, green: 20, red: 10, coverage: 128});
        send_pixel('{alpha: 255, blue: 56, green: 34, red: 12, coverage: 0});
        send_pixel('{alpha: 255, blue: 0, green: 0, red: 0, coverage: 255});
        // bright destination under bright glyph tries to push past 255
        send_pixel('{alpha: 255, blue: 255, green: 255, red: 255, coverage: 128});
        send_pixel('{alpha: 1, blue: 0, green: 128, red: 255, coverage: 200});
        send_pixel('{alpha: 128, blue: 255, green: 255, red: 255, coverage: 1});
        send_pixel('{alpha: 255, blue: 255, green: 255, red: 255, coverage: 255});
        send_pixel('{alpha: 254, blue: 50, green: 100, red: 200, coverage: 77});
        // fully transparent glyph, glyph alpha always zero
        set_glyph(8'd0, 8'd128, 8'd255, 8'd255);
        send_pixel('{alpha: 0, blue: 3, green: 2, red: 1, coverage: 255});
        send_pixel('{alpha: 100, blue: 100, green: 100, red: 100, coverage: 255});
        send_pixel('{alpha: 1, blue: 255, green: 255, red: 255, coverage: 255});
        // half transparency
        set_glyph(8'd255, 8'd0, 8'd255, 8'd128);
        send_pixel('{alpha: 0, blue: 0, green: 255, red: 0, coverage: 255});
        send_pixel('{alpha: 60, blue: 255, green: 0, red: 255, coverage: 128});
        send_pixel('{alpha: 1, blue: 255, green: 255, red: 255, coverage: 255});
        send_pixel('{alpha: 255, blue: 0, green: 0, red: 0, coverage: 0});
        send_pixel('{alpha: 2, blue: 254, green: 1, red: 255, coverage: 254});
    endtask

    task automatic run_blend_phase(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [7:0] t,
                                   input rx_mode_t mode, input bit idle_en);
        set_glyph(r, g, b, t);
        rx_mode    = mode;
        tx_idle_en = idle_en;
        burst_left = 0;
        repeat (PHASE_PIXELS)
            send_random_pixel();
    endtask

    task automatic test_random_blends();
        run_blend_phase(8'd255, 8'd255, 8'd255, 8'd0, RX_ALWAYS, 1'b0);
        run_blend_phase(8'd0, 8'd0, 8'd0, 8'd0, RX_RANDOM, 1'b1);
        run_blend_phase(8'd0, 8'd0, 8'd0, 8'd255, RX_BURSTY, 1'b1);
        run_blend_phase(8'd255, 8'd255, 8'd255, 8'd255, RX_RANDOM, 1'b0);
        run_blend_phase(8'd170, 8'd85, 8'd15, 8'd128, RX_BURSTY, 1'b0);
        repeat (3)
            run_blend_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            rx_mode_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_directed_pixels();
        test_random_blends();

        wait_idle();
        if (mismatch_count == 0)
            $display("subtitle_glyph_alpha_blend test passed");
        else
            $display("subtitle_glyph_alpha_blend test failed");
        $finish;
    end

endmodule
